>>> src/double_ended_priority_queue_unit_defines.svh
// assertion macros for the double-ended priority queue unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// property that holds at every clock edge outside reset
`define DEPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define DEPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define DEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/depq_pkg.sv
// shared types and codes of the double-ended priority queue unit
// no dependencies
package depq_pkg;

  localparam int unsigned OP_W = 2;
  localparam int unsigned ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_SERVE_HIGH = 2'd1,
    OP_SERVE_LOW  = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_SERVED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // row-wide command, at most one bit set
  typedef struct packed {
    logic ins;
    logic pop_lo;
    logic pop_hi;
  } depq_ctrl_t;

endpackage

>>> src/depq_cell.sv
// one slot of the sorted row: holds an entry and trades it with its neighbors
// depends on depq_pkg
module depq_cell #(
  parameter int unsigned ID_BITS       = 20,
  parameter int unsigned PRIORITY_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  depq_pkg::depq_ctrl_t      ctrl_i,
  input  logic [ID_BITS-1:0]        new_id_i,
  input  logic [PRIORITY_BITS-1:0]  new_prio_i,
  input  logic                      left_valid_i,
  input  logic                      left_gt_i,
  input  logic [ID_BITS-1:0]        left_id_i,
  input  logic [PRIORITY_BITS-1:0]  left_prio_i,
  input  logic                      right_valid_i,
  input  logic [ID_BITS-1:0]        right_id_i,
  input  logic [PRIORITY_BITS-1:0]  right_prio_i,
  output logic                      valid_o,
  output logic                      gt_o,
  output logic [ID_BITS-1:0]        id_o,
  output logic [PRIORITY_BITS-1:0]  prio_o
);
  import depq_pkg::*;

  logic                     valid_q, valid_d;
  logic [ID_BITS-1:0]       id_q, id_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                     gt;

  // stored entry sorts after the new one
  assign gt = valid_q && (prio_q > new_prio_i);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        // make room: take the neighbor's entry
        valid_d = left_valid_i;
        id_d    = left_id_i;
        prio_d  = left_prio_i;
      end else if (gt || (!valid_q && left_valid_i)) begin
        valid_d = 1'b1;
        id_d    = new_id_i;
        prio_d  = new_prio_i;
      end
    end else if (ctrl_i.pop_lo) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      prio_d  = right_prio_i;
    end else if (ctrl_i.pop_hi) begin
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign gt_o    = gt;
  assign id_o    = id_q;
  assign prio_o  = prio_q;

endmodule

>>> src/double_ended_priority_queue_unit.sv
// double-ended priority queue: a row of CAPACITY cells kept sorted by ascending priority
// one transaction is accepted per cycle; every cell compares and shifts in parallel
// a served or rejected result sits in the output register in the cycle after acceptance
// an insert into a free slot gives no result; input waits only while a result is stalled
// reset clears every cell's valid bit and the output valid flag: the queue starts empty
`include "double_ended_priority_queue_unit_defines.svh"

module double_ended_priority_queue_unit #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ID_BITS       = 20,
  parameter int unsigned PRIORITY_BITS = 24
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // client_id, priority_req, zero fill
  input  logic [((ID_BITS+PRIORITY_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // op
  input  logic [depq_pkg::OP_W-1:0]                     s_axis_tuser_i,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // served_id, zero fill
  output logic [((ID_BITS+7)/8)*8-1:0]                  m_axis_tdata_o,
  // status
  output logic [depq_pkg::ST_W-1:0]                     m_axis_tuser_o
);
  import depq_pkg::*;

  localparam int unsigned OUT_DATA_W = ((ID_BITS + 7) / 8) * 8;

  logic                     accept;
  op_e                      op;
  logic [ID_BITS-1:0]       new_id;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic                     full, empty;
  depq_ctrl_t               ctrl;

  logic [CAPACITY-1:0]      cell_valid, cell_gt, cell_top;
  logic [ID_BITS-1:0]       cell_id   [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  logic [ID_BITS-1:0]       top_id;

  logic                     res_valid;
  status_e                  res_status;
  logic [ID_BITS-1:0]       res_id;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  logic [ID_BITS-1:0]       out_id_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);
  assign new_id          = s_axis_tdata_i[ID_BITS-1:0];
  assign new_prio        = s_axis_tdata_i[ID_BITS+PRIORITY_BITS-1:ID_BITS];

  // valid bits form a prefix of the row
  assign full     = cell_valid[CAPACITY-1];
  assign empty    = !cell_valid[0];
  assign cell_top = cell_valid & ~(cell_valid >> 1);

  always_comb begin
    ctrl       = '0;
    res_valid  = 1'b0;
    res_status = ST_SERVED;
    res_id     = '0;
    case (op)
      OP_INSERT: begin
        ctrl.ins = accept && !full;
        if (full) begin
          res_valid  = accept;
          res_status = ST_FULL;
        end
      end
      OP_SERVE_HIGH: begin
        ctrl.pop_hi = accept && !empty;
        res_valid   = accept;
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_id = top_id;
        end
      end
      OP_SERVE_LOW: begin
        ctrl.pop_lo = accept && !empty;
        res_valid   = accept;
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_id = cell_id[0];
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // one-hot pick of the highest occupied cell
  always_comb begin
    top_id = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      top_id = top_id | (cell_id[k] & {ID_BITS{cell_top[k]}});
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     l_valid, l_gt, r_valid;
    logic [ID_BITS-1:0]       l_id, r_id;
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;

    if (k == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
      assign l_id    = '0;
      assign l_prio  = '0;
    end else begin : g_mid_l
      assign l_valid = cell_valid[k-1];
      assign l_gt    = cell_gt[k-1];
      assign l_id    = cell_id[k-1];
      assign l_prio  = cell_prio[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_prio  = '0;
    end else begin : g_mid_r
      assign r_valid = cell_valid[k+1];
      assign r_id    = cell_id[k+1];
      assign r_prio  = cell_prio[k+1];
    end

    depq_cell #(
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_id_i      (new_id),
      .new_prio_i    (new_prio),
      .left_valid_i  (l_valid),
      .left_gt_i     (l_gt),
      .left_id_i     (l_id),
      .left_prio_i   (l_prio),
      .right_valid_i (r_valid),
      .right_id_i    (r_id),
      .right_prio_i  (r_prio),
      .valid_o       (cell_valid[k]),
      .gt_o          (cell_gt[k]),
      .id_o          (cell_id[k]),
      .prio_o        (cell_prio[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_id_q);

  `DEPQ_ASSERT_ALWAYS(a_valid_prefix, ((cell_valid >> 1) & ~cell_valid) == '0, "valid bits not a prefix")
  `DEPQ_ASSERT_ALWAYS(a_top_onehot, $onehot0(cell_top), "more than one top cell")
  `DEPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, $countones(cell_valid) == $countones($past(cell_valid)) + 1, "insert did not add one entry")
  `DEPQ_ASSERT_NEXT(a_pop_shrinks, ctrl.pop_hi || ctrl.pop_lo, $countones(cell_valid) + 1 == $countones($past(cell_valid)), "serve did not remove one entry")
  `DEPQ_ASSERT_NEXT(a_reject_full, accept && op == OP_INSERT && full, m_axis_tvalid_o && m_axis_tuser_o == ST_FULL, "full insert not reported")

endmodule

>>> sim/tb_double_ended_priority_queue_unit.sv
`timescale 1ns / 100ps
// self-checking testbench of the double-ended priority queue unit: directed table, random mix
// predicts every served, empty and rejected result with a sorted-row model of its own
// depends on depq_pkg and double_ended_priority_queue_unit
module tb_double_ended_priority_queue_unit;
  import depq_pkg::*;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned ID_BITS    = 20;
  localparam int unsigned PRIO_BITS  = 24;
  localparam int unsigned IN_DATA_W  = ((ID_BITS + PRIO_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ID_BITS + 7) / 8) * 8;
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam int unsigned NUM_ROWS   = 22;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // op code that the block ignores
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam logic [ID_BITS-1:0]   ID_MAX   = '1;
  localparam logic [PRIO_BITS-1:0] PRIO_MAX = '1;

  typedef struct packed {
    status_e              status;
    logic [ID_BITS-1:0]   client;
  } depq_result_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ID_BITS-1:0]   client;
    logic [PRIO_BITS-1:0] prio;
    bit                   typed;
    status_e              exp_status;
    logic [ID_BITS-1:0]   exp_client;
  } request_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // client_id, priority_req, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // op
  logic [OP_W-1:0]       s_axis_tuser_i = OP_INSERT;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // served_id, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // status
  logic [ST_W-1:0]       m_axis_tuser_o;

  // typed expectation that travels beside a directed transaction
  bit                    typed_en = 1'b0;
  status_e               typed_status = ST_SERVED;
  logic [ID_BITS-1:0]    typed_client = '0;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  // sorted row model, ascending priority
  logic [PRIO_BITS-1:0]  row_prio [CAPACITY];
  logic [ID_BITS-1:0]    row_client [CAPACITY];
  int unsigned           row_count = 0;
  depq_result_t          pending_results [$];

  request_row_t          directed_rows [NUM_ROWS];

  double_ended_priority_queue_unit #(
    .CAPACITY      (CAPACITY),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIO_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // applies one request to the row model; returns 1 when a result is due
  function automatic bit predict_queue_step(input logic [OP_W-1:0] op,
                                            input logic [ID_BITS-1:0] client,
                                            input logic [PRIO_BITS-1:0] prio,
                                            output depq_result_t res);
    int unsigned pos;
    res = '{status: ST_SERVED, client: '0};
    case (op)
      OP_INSERT: begin
        if (row_count >= CAPACITY) begin
          res.status = ST_FULL;
          return 1'b1;
        end
        pos = 0;
        while (pos < row_count && row_prio[pos] <= prio) pos++;
        for (int unsigned k = row_count; k > pos; k--) begin
          row_prio[k]   = row_prio[k-1];
          row_client[k] = row_client[k-1];
        end
        row_prio[pos]   = prio;
        row_client[pos] = client;
        row_count++;
        return 1'b0;
      end
      OP_SERVE_HIGH, OP_SERVE_LOW: begin
        if (row_count == 0) begin
          res.status = ST_EMPTY;
          return 1'b1;
        end
        if (op == OP_SERVE_HIGH) begin
          row_count--;
          res.client = row_client[row_count];
        end else begin
          res.client = row_client[0];
          for (int unsigned k = 1; k < row_count; k++) begin
            row_prio[k-1]   = row_prio[k];
            row_client[k-1] = row_client[k];
          end
          row_count--;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // request and result monitor, plus the receiver's ready
  always @(posedge clk_i) begin
    depq_result_t res;
    depq_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (predict_queue_step(s_axis_tuser_i, s_axis_tdata_i[ID_BITS-1:0],
                               s_axis_tdata_i[ID_BITS +: PRIO_BITS], res)) begin
          if (typed_en) begin
            res.status = typed_status;
            res.client = typed_client;
          end
          pending_results = {pending_results, res};
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(m_axis_tuser_o),
                          32'(m_axis_tuser_o));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser_o !== want.status)
            report_mismatch("status", 32'(m_axis_tuser_o), 32'(want.status));
          if (m_axis_tdata_o[ID_BITS-1:0] !== want.client)
            report_mismatch("served_id", 32'(m_axis_tdata_o[ID_BITS-1:0]),
                            32'(want.client));
          if (m_axis_tdata_o[OUT_DATA_W-1:ID_BITS] !== '0)
            report_mismatch("tdata fill", 32'(m_axis_tdata_o[OUT_DATA_W-1:ID_BITS]), 0);
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // ends the run when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] client,
                              input logic [PRIO_BITS-1:0] prio, input bit typed,
                              input status_e st, input logic [ID_BITS-1:0] exp_client);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W - ID_BITS - PRIO_BITS){1'b0}}, prio, client};
    s_axis_tuser_i  <= op;
    typed_en        <= typed;
    typed_status    <= st;
    typed_client    <= exp_client;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic logic [PRIO_BITS-1:0] random_priority();
    case ($urandom_range(9))
      0, 1, 2, 3: return PRIO_BITS'($urandom_range(7));
      4:          return $urandom_range(1) ? PRIO_MAX : '0;
      default:    return PRIO_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned insert_pct;
    logic [OP_W-1:0] op;

    directed_rows = '{
      '{OP_SERVE_HIGH, '0, '0, 1'b1, ST_EMPTY, '0},
      '{OP_SERVE_LOW, ID_MAX, PRIO_MAX, 1'b1, ST_EMPTY, '0},
      '{OP_IGNORED, ID_MAX, PRIO_MAX, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, ID_MAX, PRIO_MAX, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, '0, '0, 1'b1, ST_SERVED, ID_MAX},
      '{OP_SERVE_LOW, '0, '0, 1'b1, ST_SERVED, '0},
      '{OP_SERVE_LOW, '0, '0, 1'b1, ST_EMPTY, '0},
      // three entries with equal priority
      '{OP_INSERT, 20'd1, 24'd5, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, 20'd2, 24'd5, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, 20'd3, 24'd5, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, 20'd4, 24'h800000, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_LOW, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_LOW, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, 20'hAAAAA, 24'h555555, 1'b0, ST_SERVED, '0},
      '{OP_INSERT, 20'h55555, 24'hAAAAAA, 1'b0, ST_SERVED, '0},
      '{OP_IGNORED, 20'h12345, 24'h000001, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, ID_MAX, PRIO_MAX, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, '0, '0, 1'b0, ST_SERVED, '0},
      '{OP_SERVE_HIGH, '0, '0, 1'b1, ST_EMPTY, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].client, directed_rows[i].prio,
                   directed_rows[i].typed, directed_rows[i].exp_status,
                   directed_rows[i].exp_client);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // fill, drain or mixed stretch so both the full and the empty ends are reached
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
        seg_len = $urandom_range(120, 20);
        for (int unsigned n = 0; n < seg_len && sent < ITEMS_PER_PHASE; n++) begin
          if ($urandom_range(99) < 3) op = OP_IGNORED;
          else if ($urandom_range(99) < insert_pct) op = OP_INSERT;
          else op = $urandom_range(1) ? OP_SERVE_HIGH : OP_SERVE_LOW;
          send_request(op, ID_BITS'($urandom), random_priority(), 1'b0, ST_SERVED, '0);
          if (op != OP_IGNORED) sent++;
        end
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
